@@ rtl/eyc_pkg.sv @@
// ----------------------------------------------------------------------------
// Epoch year converter package
// Shared types and constants for the seconds-to-year and year-to-seconds
// pipeline: division constants, calendar cycle lengths and sideband records.
// ----------------------------------------------------------------------------
package eyc_pkg;

    // Operation selector carried in the input tuser.
    localparam logic MODE_YEAR_OF_SECS  = 1'b0;
    localparam logic MODE_START_OF_YEAR = 1'b1;

    // Accepted range of input seconds; years in it beyond a signed 32-bit value are flagged by the calendar stages.
    localparam logic signed [63:0] T_MIN = -64'sd2147483648 * 64'sd31622400;
    localparam logic signed [63:0] T_MAX = 64'sd2147483647 * 64'sd31622400;

    // One day is 128 * 675 seconds; the power-of-two part is a plain shift.
    localparam int DAY_SHIFT = 7;

    // First divider: (seconds / 128) by 675 days-worth times one 400-year cycle.
    localparam int                     DIV1_DW  = 51;
    localparam int                     DIV1_QW  = 24;
    localparam int                     DIV1_RW  = 27;
    localparam int                     DIV1_SPS = 4;
    localparam longint unsigned        DIV1_D   = 64'd98615475;
    // Bias of 2^23 times the divisor keeps the dividend positive; the leap epoch
    // (2000-03-01) divided by 128 is folded in as well.
    localparam logic signed [63:0]     DIV1_OFFSET =
        64'sd8388608 * 64'sd98615475 - 64'sd7436475;
    localparam logic signed [24:0]     QC_BIAS  = 25'sd8388608;

    // Second divider: remainder of the cycle split into days.
    localparam int                     DIV2_QW  = 18;
    localparam int                     DIV2_SPS = 6;
    localparam longint unsigned        DIV2_D   = 64'd675;

    // Calendar cycle lengths in days.
    localparam logic [17:0] DAYS_100Y_1 = 18'd36524;
    localparam logic [17:0] DAYS_100Y_2 = 18'd73048;
    localparam logic [17:0] DAYS_100Y_3 = 18'd109572;
    localparam logic [15:0] DAYS_4Y     = 16'd1461;
    localparam int          Q_BITS      = 5;
    localparam logic [10:0] DAYS_1Y_1   = 11'd365;
    localparam logic [10:0] DAYS_1Y_2   = 11'd730;
    localparam logic [10:0] DAYS_1Y_3   = 11'd1095;
    localparam logic [8:0]  MARCH_TO_DEC_DAYS = 9'd306;

    localparam logic signed [34:0] YEAR_BASE   = 35'sd2000;
    localparam logic signed [34:0] YEAR_MAX    = 35'sd2147483647;
    localparam logic signed [34:0] YEAR_MIN    = -35'sd2147483648;
    localparam logic signed [31:0] ERROR_YEAR  = 32'sd1899;

    // Third divider: (year / 16) by 25, i.e. year by 400 in two parts.
    localparam int                 YEAR_SHIFT  = 4;
    localparam int                 DIV3_DW     = 30;
    localparam int                 DIV3_QW     = 26;
    localparam int                 DIV3_SPS    = 8;
    localparam longint unsigned    DIV3_D      = 64'd25;
    // 25 * 2^24 bias minus 2000 / 16.
    localparam logic signed [31:0] DIV3_OFFSET = 32'sd419430275;
    localparam logic signed [26:0] CYC_BIAS    = 27'sd16777216;

    localparam logic [8:0]  REM_100 = 9'd100;
    localparam logic [8:0]  REM_200 = 9'd200;
    localparam logic [8:0]  REM_300 = 9'd300;

    localparam logic signed [32:0] YEAR_EPOCH   = 33'sd2000;
    localparam logic signed [63:0] SECS_YEAR    = 64'sd31536000;
    localparam logic signed [63:0] SECS_DAY     = 64'sd86400;
    localparam logic signed [63:0] SECS_BASE    = 64'sd946771200;
    localparam logic signed [31:0] LEAPS_CYCLE  = 32'sd97;
    localparam logic signed [31:0] LEAPS_CENT   = 32'sd24;

    // Sideband that follows an item through the day divisions.
    typedef struct packed {
        logic               mode;
        logic               err;
        logic signed [31:0] year_in;
    } eyc_tag_t;

    typedef struct packed {
        eyc_tag_t           tag;
        logic [DIV1_QW-1:0] qc_b;
    } eyc_cyc_tag_t;

    // Resolved year handed to the start-of-year stages.
    typedef struct packed {
        logic signed [31:0] year;
        logic               err;
    } eyc_year_t;

endpackage

@@ rtl/eyc_cdiv.sv @@
// ----------------------------------------------------------------------------
// Pipelined divider by a constant
// Restoring long division of an unsigned dividend by a fixed divisor, a few
// quotient bits per register stage, with a sideband that travels alongside.
// ----------------------------------------------------------------------------
module eyc_cdiv #(
    parameter int              DW      = 30,
    parameter int              QW      = 26,
    parameter longint unsigned DIVISOR = 25,
    parameter int              SPS     = 8,
    parameter int              SW      = 1,
    localparam int             RW      = $clog2(DIVISOR + 1)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [DW-1:0] dividend,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [QW-1:0] quotient,
    output logic [RW-1:0] remainder,
    output logic [SW-1:0] out_side
);

    localparam int           NST = (QW + SPS - 1) / SPS;
    localparam logic [RW:0]  D_W = (RW + 1)'(DIVISOR);

    // Index 0 is the input side, index k+1 the register of stage k.
    logic [RW-1:0] rem_pipe  [NST+1];
    logic [QW-1:0] low_pipe  [NST+1];
    logic [QW-1:0] quo_pipe  [NST+1];
    logic [SW-1:0] side_pipe [NST+1];
    logic          vld_pipe  [NST+1];
    logic          rdy_pipe  [NST+1];

    // The upper dividend bits are already below the divisor.
    assign rem_pipe[0]   = RW'(dividend[DW-1:QW]);
    assign low_pipe[0]   = dividend[QW-1:0];
    assign quo_pipe[0]   = '0;
    assign side_pipe[0]  = in_side;
    assign vld_pipe[0]   = in_valid;
    assign rdy_pipe[NST] = out_ready;
    assign in_ready      = rdy_pipe[0];

    for (genvar k = 0; k < NST; k++) begin : g_stage
        localparam int NS = (QW - k * SPS < SPS) ? (QW - k * SPS) : SPS;

        logic [RW:0]   trial;
        logic [RW-1:0] rem_next;
        logic [QW-1:0] low_next;
        logic [QW-1:0] quo_next;
        logic          vld_reg;
        logic [RW-1:0] rem_reg;
        logic [QW-1:0] low_reg;
        logic [QW-1:0] quo_reg;
        logic [SW-1:0] side_reg;

        // Shift in one dividend bit per step and subtract where it fits.
        always_comb
        begin
            trial    = '0;
            rem_next = rem_pipe[k];
            low_next = low_pipe[k];
            quo_next = quo_pipe[k];
            for (int i = 0; i < NS; i++)
            begin
                trial    = {rem_next, low_next[QW-1]};
                low_next = low_next << 1;
                if (trial >= D_W)
                begin
                    rem_next = RW'(trial - D_W);
                    quo_next = {quo_next[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[RW-1:0];
                    quo_next = {quo_next[QW-2:0], 1'b0};
                end
            end
        end

        // The stage takes a new beat when it is empty or its successor moves.
        assign rdy_pipe[k] = !vld_reg || rdy_pipe[k+1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg <= 1'b0;
            end
            else if (rdy_pipe[k])
            begin
                vld_reg <= vld_pipe[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (rdy_pipe[k] && vld_pipe[k])
            begin
                rem_reg  <= rem_next;
                low_reg  <= low_next;
                quo_reg  <= quo_next;
                side_reg <= side_pipe[k];
            end
        end

        assign vld_pipe[k+1]  = vld_reg;
        assign rem_pipe[k+1]  = rem_reg;
        assign low_pipe[k+1]  = low_reg;
        assign quo_pipe[k+1]  = quo_reg;
        assign side_pipe[k+1] = side_reg;
    end

    assign out_valid = vld_pipe[NST];
    assign quotient  = quo_pipe[NST];
    assign remainder = rem_pipe[NST];
    assign out_side  = side_pipe[NST];

endmodule

@@ rtl/eyc_calendar.sv @@
// ----------------------------------------------------------------------------
// Calendar year decomposition
// Splits the day within a 400-year cycle into centuries, 4-year groups and
// single years, forms the calendar year and resolves mode and range errors.
// ----------------------------------------------------------------------------
module eyc_calendar (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [eyc_pkg::DIV2_QW-1:0] rd,
    input  eyc_pkg::eyc_cyc_tag_t       in_side,
    output logic                        out_valid,
    input  logic                        out_ready,
    output eyc_pkg::eyc_year_t          out_year
);

    import eyc_pkg::*;

    logic c1_rdy, c2_rdy, c3_rdy, c4_rdy;

    // Stage 1: centuries and the 400-year cycle count.
    logic               c1_vld_reg;
    logic [1:0]         c1_c_reg, c1_c_next;
    logic [15:0]        c1_rd_reg, c1_rd_next;
    logic signed [24:0] c1_qc_reg, c1_qc_next;
    eyc_tag_t           c1_tag_reg;
    logic               ge1, ge2, ge3;

    // Stage 2: 4-year groups.
    logic               c2_vld_reg;
    logic [1:0]         c2_c_reg;
    logic [Q_BITS-1:0]  c2_q_reg, c2_q_next;
    logic [10:0]        c2_r_reg, c2_r_next;
    logic [15:0]        c2_work;
    logic signed [24:0] c2_qc_reg;
    eyc_tag_t           c2_tag_reg;

    // Stage 3: single years and the small part of the year.
    logic               c3_vld_reg;
    logic [8:0]         c3_ys_reg, c3_ys_next;
    logic signed [24:0] c3_qc_reg;
    eyc_tag_t           c3_tag_reg;
    logic [1:0]         ry;
    logic [10:0]        rd3;

    // Stage 4: full year, overflow check and mode select.
    logic               c4_vld_reg;
    eyc_year_t          c4_year_reg, c4_year_next;
    logic signed [34:0] full;
    logic               ovf;

    assign c4_rdy   = !c4_vld_reg || out_ready;
    assign c3_rdy   = !c3_vld_reg || c4_rdy;
    assign c2_rdy   = !c2_vld_reg || c3_rdy;
    assign c1_rdy   = !c1_vld_reg || c2_rdy;
    assign in_ready = c1_rdy;

    // The last day of a 400-year cycle stays in the fourth century.
    always_comb
    begin
        ge1 = rd >= DAYS_100Y_1;
        ge2 = rd >= DAYS_100Y_2;
        ge3 = rd >= DAYS_100Y_3;
        c1_c_next = 2'(ge1) + 2'(ge2) + 2'(ge3);
        if (ge3)
        begin
            c1_rd_next = 16'(rd - DAYS_100Y_3);
        end
        else if (ge2)
        begin
            c1_rd_next = 16'(rd - DAYS_100Y_2);
        end
        else if (ge1)
        begin
            c1_rd_next = 16'(rd - DAYS_100Y_1);
        end
        else
        begin
            c1_rd_next = 16'(rd);
        end
        c1_qc_next = signed'(25'(in_side.qc_b)) - QC_BIAS;
    end

    // Day within the century by 1461; it never reaches 25 groups.
    always_comb
    begin
        c2_work   = c1_rd_reg;
        c2_q_next = '0;
        for (int j = Q_BITS - 1; j >= 0; j--)
        begin
            if (c2_work >= (DAYS_4Y << j))
            begin
                c2_work   = c2_work - (DAYS_4Y << j);
                c2_q_next = {c2_q_next[Q_BITS-2:0], 1'b1};
            end
            else
            begin
                c2_q_next = {c2_q_next[Q_BITS-2:0], 1'b0};
            end
        end
        c2_r_next = 11'(c2_work);
    end

    // Year within the group, capped at the fourth; March onward is this year.
    always_comb
    begin
        ry = 2'(c2_r_reg >= DAYS_1Y_1) + 2'(c2_r_reg >= DAYS_1Y_2)
           + 2'(c2_r_reg >= DAYS_1Y_3);
        if (c2_r_reg >= DAYS_1Y_3)
        begin
            rd3 = c2_r_reg - DAYS_1Y_3;
        end
        else if (c2_r_reg >= DAYS_1Y_2)
        begin
            rd3 = c2_r_reg - DAYS_1Y_2;
        end
        else if (c2_r_reg >= DAYS_1Y_1)
        begin
            rd3 = c2_r_reg - DAYS_1Y_1;
        end
        else
        begin
            rd3 = c2_r_reg;
        end
        c3_ys_next = 9'(ry) + {2'b00, c2_q_reg, 2'b00} + 9'(c2_c_reg) * 9'd100
                   + 9'(rd3 >= 11'(MARCH_TO_DEC_DAYS));
    end

    // Whole year and the final choice of year and error flag.
    always_comb
    begin
        full = 35'(c3_qc_reg) * 35'sd400 + YEAR_BASE + signed'(35'(c3_ys_reg));
        ovf  = (full > YEAR_MAX) || (full < YEAR_MIN);
        if (c3_tag_reg.mode == MODE_START_OF_YEAR)
        begin
            c4_year_next.year = c3_tag_reg.year_in;
            c4_year_next.err  = 1'b0;
        end
        else if (c3_tag_reg.err || ovf)
        begin
            c4_year_next.year = ERROR_YEAR;
            c4_year_next.err  = 1'b1;
        end
        else
        begin
            c4_year_next.year = full[31:0];
            c4_year_next.err  = 1'b0;
        end
    end

    // Valid bits of the four stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_vld_reg <= 1'b0;
            c2_vld_reg <= 1'b0;
            c3_vld_reg <= 1'b0;
            c4_vld_reg <= 1'b0;
        end
        else
        begin
            if (c1_rdy)
            begin
                c1_vld_reg <= in_valid;
            end
            if (c2_rdy)
            begin
                c2_vld_reg <= c1_vld_reg;
            end
            if (c3_rdy)
            begin
                c3_vld_reg <= c2_vld_reg;
            end
            if (c4_rdy)
            begin
                c4_vld_reg <= c3_vld_reg;
            end
        end
    end

    // Payload registers load only with a beat.
    always_ff @(posedge clk)
    begin
        if (c1_rdy && in_valid)
        begin
            c1_c_reg   <= c1_c_next;
            c1_rd_reg  <= c1_rd_next;
            c1_qc_reg  <= c1_qc_next;
            c1_tag_reg <= in_side.tag;
        end
        if (c2_rdy && c1_vld_reg)
        begin
            c2_c_reg   <= c1_c_reg;
            c2_q_reg   <= c2_q_next;
            c2_r_reg   <= c2_r_next;
            c2_qc_reg  <= c1_qc_reg;
            c2_tag_reg <= c1_tag_reg;
        end
        if (c3_rdy && c2_vld_reg)
        begin
            c3_ys_reg  <= c3_ys_next;
            c3_qc_reg  <= c2_qc_reg;
            c3_tag_reg <= c2_tag_reg;
        end
        if (c4_rdy && c3_vld_reg)
        begin
            c4_year_reg <= c4_year_next;
        end
    end

    assign out_valid = c4_vld_reg;
    assign out_year  = c4_year_reg;

endmodule

@@ rtl/eyc_year_start.sv @@
// ----------------------------------------------------------------------------
// Start-of-year seconds
// Splits the year into 400-year cycles, centuries and leap years, counts the
// leap days and forms the Unix second of January 1 of that year.
// ----------------------------------------------------------------------------
module eyc_year_start (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  eyc_pkg::eyc_year_t in_year,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_year_val,
    output logic signed [63:0] out_seconds,
    output logic               out_err
);

    import eyc_pkg::*;

    localparam int RW3 = $clog2(DIV3_D + 1);

    logic y0_rdy, y1_rdy, y2_rdy, y3_rdy, y4_rdy;

    // Stage 0: biased year / 16 as dividend.
    logic                 y0_vld_reg;
    logic [DIV3_DW-1:0]   y0_x_reg;
    logic signed [31:0]   y0_x_next;
    eyc_year_t            y0_year_reg;

    // Divider handshake and outputs.
    logic                 d3_in_ready;
    logic                 d3_vld;
    logic [DIV3_QW-1:0]   d3_quo;
    logic [RW3-1:0]       d3_rem;
    eyc_year_t            d3_year;

    // Stage 1: cycles, centuries and leap years within the century.
    logic                 y1_vld_reg;
    logic signed [26:0]   y1_cyc_reg, y1_cyc_next;
    logic [1:0]           y1_cent_reg, y1_cent_next;
    logic [4:0]           y1_leaps_reg, y1_leaps_next;
    logic                 y1_leap_reg, y1_leap_next;
    eyc_year_t            y1_year_reg;
    logic [8:0]           rem400;
    logic [6:0]           rem2;

    // Stage 2: total leap days and year offset.
    logic                 y2_vld_reg;
    logic signed [31:0]   y2_lt_reg, y2_lt_next;
    logic signed [32:0]   y2_r_reg, y2_r_next;
    eyc_year_t            y2_year_reg;

    // Stage 3: products.
    logic                 y3_vld_reg;
    logic signed [63:0]   y3_p1_reg, y3_p2_reg;
    eyc_year_t            y3_year_reg;

    // Stage 4: output register.
    logic                 y4_vld_reg;
    logic signed [63:0]   y4_sec_reg;
    eyc_year_t            y4_year_reg;

    assign y4_rdy   = !y4_vld_reg || out_ready;
    assign y3_rdy   = !y3_vld_reg || y4_rdy;
    assign y2_rdy   = !y2_vld_reg || y3_rdy;
    assign y0_rdy   = !y0_vld_reg || d3_in_ready;
    assign in_ready = y0_rdy;

    // Year minus 2000 divided by 16 stays exact since 2000 is a multiple of 16.
    assign y0_x_next = (in_year.year >>> YEAR_SHIFT) + DIV3_OFFSET;

    eyc_cdiv #(
        .DW      (DIV3_DW),
        .QW      (DIV3_QW),
        .DIVISOR (DIV3_D),
        .SPS     (DIV3_SPS),
        .SW      ($bits(eyc_year_t))
    ) u_div_cycle (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (y0_vld_reg),
        .in_ready  (d3_in_ready),
        .dividend  (y0_x_reg),
        .in_side   (y0_year_reg),
        .out_valid (d3_vld),
        .out_ready (y1_rdy),
        .quotient  (d3_quo),
        .remainder (d3_rem),
        .out_side  (d3_year)
    );

    assign y1_rdy = !y1_vld_reg || y2_rdy;

    // Position within the 400-year cycle and the leap rule.
    always_comb
    begin
        y1_cyc_next  = signed'(27'(d3_quo)) - CYC_BIAS;
        rem400       = {d3_rem[4:0], d3_year.year[YEAR_SHIFT-1:0]};
        y1_cent_next = 2'(rem400 >= REM_100) + 2'(rem400 >= REM_200)
                     + 2'(rem400 >= REM_300);
        if (rem400 >= REM_300)
        begin
            rem2 = 7'(rem400 - REM_300);
        end
        else if (rem400 >= REM_200)
        begin
            rem2 = 7'(rem400 - REM_200);
        end
        else if (rem400 >= REM_100)
        begin
            rem2 = 7'(rem400 - REM_100);
        end
        else
        begin
            rem2 = 7'(rem400);
        end
        if (rem400 == '0)
        begin
            // First year of a 400-year cycle is a leap year.
            y1_leaps_next = '0;
            y1_leap_next  = 1'b1;
        end
        else if (rem2 != '0)
        begin
            y1_leaps_next = rem2[6:2];
            y1_leap_next  = (rem2[1:0] == 2'b00);
        end
        else
        begin
            y1_leaps_next = '0;
            y1_leap_next  = 1'b0;
        end
    end

    // Leap days before the year and years after 2000.
    always_comb
    begin
        y2_lt_next = 32'(y1_cyc_reg) * LEAPS_CYCLE
                   + signed'(32'(y1_cent_reg)) * LEAPS_CENT
                   + signed'(32'(y1_leaps_reg))
                   - signed'(32'(y1_leap_reg));
        y2_r_next  = 33'(y1_year_reg.year) - YEAR_EPOCH;
    end

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            y0_vld_reg <= 1'b0;
            y1_vld_reg <= 1'b0;
            y2_vld_reg <= 1'b0;
            y3_vld_reg <= 1'b0;
            y4_vld_reg <= 1'b0;
        end
        else
        begin
            if (y0_rdy)
            begin
                y0_vld_reg <= in_valid;
            end
            if (y1_rdy)
            begin
                y1_vld_reg <= d3_vld;
            end
            if (y2_rdy)
            begin
                y2_vld_reg <= y1_vld_reg;
            end
            if (y3_rdy)
            begin
                y3_vld_reg <= y2_vld_reg;
            end
            if (y4_rdy)
            begin
                y4_vld_reg <= y3_vld_reg;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (y0_rdy && in_valid)
        begin
            y0_x_reg    <= y0_x_next[DIV3_DW-1:0];
            y0_year_reg <= in_year;
        end
        if (y1_rdy && d3_vld)
        begin
            y1_cyc_reg   <= y1_cyc_next;
            y1_cent_reg  <= y1_cent_next;
            y1_leaps_reg <= y1_leaps_next;
            y1_leap_reg  <= y1_leap_next;
            y1_year_reg  <= d3_year;
        end
        if (y2_rdy && y1_vld_reg)
        begin
            y2_lt_reg   <= y2_lt_next;
            y2_r_reg    <= y2_r_next;
            y2_year_reg <= y1_year_reg;
        end
        if (y3_rdy && y2_vld_reg)
        begin
            y3_p1_reg   <= 64'(y2_r_reg) * SECS_YEAR;
            y3_p2_reg   <= 64'(y2_lt_reg) * SECS_DAY;
            y3_year_reg <= y2_year_reg;
        end
        if (y4_rdy && y3_vld_reg)
        begin
            y4_sec_reg  <= y3_p1_reg + y3_p2_reg + SECS_BASE;
            y4_year_reg <= y3_year_reg;
        end
    end

    assign out_valid    = y4_vld_reg;
    assign out_year_val = y4_year_reg.year;
    assign out_err      = y4_year_reg.err;
    assign out_seconds  = y4_sec_reg;

endmodule

@@ rtl/epoch_year_converter.sv @@
// ----------------------------------------------------------------------------
// Epoch year converter
// Converts signed Unix seconds to the proleptic Gregorian year and its start
// second, or a year to its start second, in a fully pipelined datapath.
// ----------------------------------------------------------------------------
// The block takes one beat per clock while the output side does not stall
// and returns one beat per input beat, in order. The three constant
// dividers resolve four, six and eight quotient bits per stage. The pipeline
// holds 1 input stage, 6 stages to split seconds into 400-year
// cycles, 3 stages for the day within the cycle, 4 calendar stages, then
// 1 + 4 stages to divide the year by 400 and 4 stages for leap days and the
// final multiply-add. Each stage holds its beat while the next one is full,
// so bubbles close up and back-pressure loses nothing. Seconds whose year
// does not fit in 32 bits return year 1899 with range_error set.
module epoch_year_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [63:0] seconds_in, [95:64] year_in
    input  logic [95:0] s_axis_tdata,
    // [0] mode
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] year_out, [95:32] seconds_out
    output logic [95:0] m_axis_tdata,
    // [0] range_error
    output logic        m_axis_tuser
);

    import eyc_pkg::*;

    // Input stage.
    logic                 f_vld_reg;
    logic                 f_rdy;
    logic [DIV1_DW-1:0]   f_x_reg, f_x_next;
    eyc_tag_t             f_tag_reg, f_tag_next;
    logic signed [63:0]   seconds;
    logic signed [63:0]   biased;
    logic                 out_of_range;

    // Between the dividers and the calendar stages.
    logic                 d1_in_ready;
    logic                 d1_vld;
    logic [DIV1_QW-1:0]   d1_quo;
    logic [DIV1_RW-1:0]   d1_rem;
    eyc_tag_t             d1_tag;
    eyc_cyc_tag_t         d2_in_side;
    logic                 d2_in_ready;
    logic                 d2_vld;
    logic [DIV2_QW-1:0]   d2_quo;
    eyc_cyc_tag_t         d2_side;
    logic                 cal_in_ready;
    logic                 cal_vld;
    eyc_year_t            cal_year;
    logic                 ys_in_ready;
    logic signed [31:0]   ys_year;
    logic signed [63:0]   ys_seconds;
    logic                 ys_err;

    assign f_rdy         = !f_vld_reg || d1_in_ready;
    assign s_axis_tready = f_rdy;

    // Range check and the biased day-cycle dividend in one add.
    always_comb
    begin
        seconds      = signed'(s_axis_tdata[63:0]);
        out_of_range = (seconds < T_MIN) || (seconds > T_MAX);
        biased       = (seconds >>> DAY_SHIFT) + DIV1_OFFSET;
        f_tag_next.mode    = s_axis_tuser;
        f_tag_next.err     = (s_axis_tuser == MODE_YEAR_OF_SECS) && out_of_range;
        f_tag_next.year_in = signed'(s_axis_tdata[95:64]);
        if ((s_axis_tuser == MODE_START_OF_YEAR) || out_of_range)
        begin
            f_x_next = '0;
        end
        else
        begin
            f_x_next = biased[DIV1_DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_vld_reg <= 1'b0;
        end
        else if (f_rdy)
        begin
            f_vld_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_rdy && s_axis_tvalid)
        begin
            f_x_reg   <= f_x_next;
            f_tag_reg <= f_tag_next;
        end
    end

    // Seconds / 128 into 400-year cycles and a remainder.
    eyc_cdiv #(
        .DW      (DIV1_DW),
        .QW      (DIV1_QW),
        .DIVISOR (DIV1_D),
        .SPS     (DIV1_SPS),
        .SW      ($bits(eyc_tag_t))
    ) u_div_cycle (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_vld_reg),
        .in_ready  (d1_in_ready),
        .dividend  (f_x_reg),
        .in_side   (f_tag_reg),
        .out_valid (d1_vld),
        .out_ready (d2_in_ready),
        .quotient  (d1_quo),
        .remainder (d1_rem),
        .out_side  (d1_tag)
    );

    assign d2_in_side.tag  = d1_tag;
    assign d2_in_side.qc_b = d1_quo;

    // Remainder into whole days of the cycle.
    eyc_cdiv #(
        .DW      (DIV1_RW),
        .QW      (DIV2_QW),
        .DIVISOR (DIV2_D),
        .SPS     (DIV2_SPS),
        .SW      ($bits(eyc_cyc_tag_t))
    ) u_div_day (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d1_vld),
        .in_ready  (d2_in_ready),
        .dividend  (d1_rem),
        .in_side   (d2_in_side),
        .out_valid (d2_vld),
        .out_ready (cal_in_ready),
        .quotient  (d2_quo),
        .remainder (),
        .out_side  (d2_side)
    );

    eyc_calendar u_calendar (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d2_vld),
        .in_ready  (cal_in_ready),
        .rd        (d2_quo),
        .in_side   (d2_side),
        .out_valid (cal_vld),
        .out_ready (ys_in_ready),
        .out_year  (cal_year)
    );

    eyc_year_start u_year_start (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (cal_vld),
        .in_ready     (ys_in_ready),
        .in_year      (cal_year),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_year_val (ys_year),
        .out_seconds  (ys_seconds),
        .out_err      (ys_err)
    );

    assign m_axis_tdata = {ys_seconds, ys_year};
    assign m_axis_tuser = ys_err;

endmodule
